// ===== design/nfcs_pkg.sv =====
package nfcs_pkg;

  // Widths of the item and result fields
  localparam int OPCODE_W = 3;
  localparam int POS_W    = 23;
  localparam int SIZE_W   = 24;
  localparam int WADDR_W  = 22;
  localparam int DATA_W   = 16;
  localparam int WAIT_W   = 15;
  localparam int STEP_W   = 3;

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_READ   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PROG   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SECTOR = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_BLOCK  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SEEK   = 3'd4;

  // Bus sequence kinds handed from front to back
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_NOBUS  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PROG   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SECTOR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BLOCK  = 3'd4;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Flash geometry and command set
  localparam logic [SIZE_W-1:0]  POS_LIMIT    = 24'd8388608;
  localparam logic [SIZE_W-1:0]  WORD_STEP    = 24'd2;
  localparam int                 SECTOR_BYTES = 4096;
  localparam int                 BLOCK_BYTES  = 65536;
  localparam int                 SECTOR_LSB   = $clog2(SECTOR_BYTES);
  localparam int                 BLOCK_LSB    = $clog2(BLOCK_BYTES);
  localparam logic [WADDR_W-1:0] UNLOCK_A     = 22'h005555;
  localparam logic [WADDR_W-1:0] UNLOCK_B     = 22'h002AAA;
  localparam logic [DATA_W-1:0]  CMD_AA       = 16'h00AA;
  localparam logic [DATA_W-1:0]  CMD_55       = 16'h0055;
  localparam logic [DATA_W-1:0]  CMD_80       = 16'h0080;
  localparam logic [DATA_W-1:0]  CMD_A0       = 16'h00A0;
  localparam logic [DATA_W-1:0]  CMD_BLOCK    = 16'h0050;
  localparam logic [DATA_W-1:0]  CMD_SECTOR   = 16'h0030;
  localparam logic [WAIT_W-1:0]  WAIT_PROG    = 15'd10;
  localparam logic [WAIT_W-1:0]  WAIT_ERASE   = 15'd25000;

  // Queue depth between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [WADDR_W-1:0] addr;
    logic [DATA_W-1:0]  data;
    logic               status;
    logic [POS_W-1:0]   position;
  } op_t;

  typedef struct packed {
    logic               bus_valid;
    logic               bus_write;
    logic [WADDR_W-1:0] bus_word_addr;
    logic [DATA_W-1:0]  bus_data;
    logic               status;
    logic [POS_W-1:0]   position;
    logic [WAIT_W-1:0]  wait_us;
    logic               last;
  } res_t;

  function automatic res_t bus_cycle(logic [WADDR_W-1:0] addr, logic [DATA_W-1:0] data,
                                     logic [POS_W-1:0] position,
                                     logic [WAIT_W-1:0] wait_us, logic last);
    res_t r;
    r.bus_valid     = 1'b1;
    r.bus_write     = 1'b1;
    r.bus_word_addr = addr;
    r.bus_data      = data;
    r.status        = STATUS_OK;
    r.position      = position;
    r.wait_us       = wait_us;
    r.last          = last;
    return r;
  endfunction

  // One result of an operation's bus sequence, selected by step
  function automatic res_t seq_result(op_t op, logic [STEP_W-1:0] step);
    res_t             r;
    logic [DATA_W-1:0] erase_cmd;
    r = '0;
    r.position = op.position;
    erase_cmd = (op.kind == KIND_BLOCK) ? CMD_BLOCK : CMD_SECTOR;
    unique case (op.kind)
      KIND_READ: begin
        r.bus_valid     = 1'b1;
        r.bus_word_addr = op.addr;
        r.last          = 1'b1;
      end
      KIND_PROG: begin
        unique case (step)
          3'd0: r = bus_cycle(UNLOCK_A, CMD_AA, op.position, '0, 1'b0);
          3'd1: r = bus_cycle(UNLOCK_B, CMD_55, op.position, '0, 1'b0);
          3'd2: r = bus_cycle(UNLOCK_A, CMD_A0, op.position, '0, 1'b0);
          default: r = bus_cycle(op.addr, op.data, op.position, WAIT_PROG, 1'b1);
        endcase
      end
      KIND_SECTOR, KIND_BLOCK: begin
        unique case (step)
          3'd0: r = bus_cycle(UNLOCK_A, CMD_AA, op.position, '0, 1'b0);
          3'd1: r = bus_cycle(UNLOCK_B, CMD_55, op.position, '0, 1'b0);
          3'd2: r = bus_cycle(UNLOCK_A, CMD_80, op.position, '0, 1'b0);
          3'd3: r = bus_cycle(UNLOCK_A, CMD_AA, op.position, '0, 1'b0);
          3'd4: r = bus_cycle(UNLOCK_B, CMD_55, op.position, '0, 1'b0);
          default: r = bus_cycle(op.addr, erase_cmd, op.position, WAIT_ERASE, 1'b1);
        endcase
      end
      default: begin
        r.status = op.status;
        r.last   = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== design/nfcs_front.sv =====
module nfcs_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic [nfcs_pkg::SIZE_W-1:0]  cfg_data,
  input  logic                         push,
  input  logic [nfcs_pkg::OPCODE_W-1:0] opcode,
  input  logic [nfcs_pkg::POS_W-1:0]   target_addr,
  input  logic [nfcs_pkg::DATA_W-1:0]  write_data,
  output nfcs_pkg::op_t                op
);

  logic [nfcs_pkg::SIZE_W-1:0] flash_size_r;
  logic [nfcs_pkg::POS_W-1:0]  offset_r, offset_nxt;
  logic [nfcs_pkg::SIZE_W-1:0] eff_size, next_pos;
  logic [nfcs_pkg::POS_W-1:0]  adv_pos;
  logic                        pos_bad, tgt_bad;

  assign eff_size = (flash_size_r > nfcs_pkg::POS_LIMIT) ? nfcs_pkg::POS_LIMIT : flash_size_r;
  assign pos_bad  = {1'b0, offset_r} >= eff_size;
  assign tgt_bad  = {1'b0, target_addr} >= eff_size;
  assign next_pos = {1'b0, offset_r} + nfcs_pkg::WORD_STEP;
  assign adv_pos  = (next_pos >= eff_size) ? '0 : next_pos[nfcs_pkg::POS_W-1:0];

  always_comb begin
    op          = '0;
    op.position = offset_r;
    offset_nxt  = offset_r;
    unique case (opcode)
      nfcs_pkg::OP_READ, nfcs_pkg::OP_PROG: begin
        if (pos_bad) begin
          op.kind     = nfcs_pkg::KIND_NOBUS;
          op.status   = nfcs_pkg::STATUS_ERR;
          op.position = '0;
          offset_nxt  = '0;
        end else begin
          op.kind     = (opcode == nfcs_pkg::OP_READ) ? nfcs_pkg::KIND_READ
                                                      : nfcs_pkg::KIND_PROG;
          op.addr     = offset_r[nfcs_pkg::POS_W-1:1];
          op.data     = write_data;
          op.position = adv_pos;
          offset_nxt  = adv_pos;
        end
      end
      nfcs_pkg::OP_SECTOR: begin
        if (tgt_bad || (target_addr[nfcs_pkg::SECTOR_LSB-1:0] != '0)) begin
          op.status = nfcs_pkg::STATUS_ERR;
        end else begin
          op.kind = nfcs_pkg::KIND_SECTOR;
          op.addr = target_addr[nfcs_pkg::POS_W-1:1];
        end
      end
      nfcs_pkg::OP_BLOCK: begin
        if (tgt_bad || (target_addr[nfcs_pkg::BLOCK_LSB-1:0] != '0)) begin
          op.status = nfcs_pkg::STATUS_ERR;
        end else begin
          op.kind = nfcs_pkg::KIND_BLOCK;
          op.addr = target_addr[nfcs_pkg::POS_W-1:1];
        end
      end
      nfcs_pkg::OP_SEEK: begin
        if (tgt_bad) begin
          op.status = nfcs_pkg::STATUS_ERR;
        end else begin
          op.position = target_addr;
          offset_nxt  = target_addr;
        end
      end
      default: begin
        op.status = nfcs_pkg::STATUS_ERR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_size_r <= nfcs_pkg::POS_LIMIT;
      offset_r     <= '0;
    end else begin
      if (cfg_valid) begin
        flash_size_r <= cfg_data;
      end
      if (push) begin
        offset_r <= offset_nxt;
      end
    end
  end

endmodule

// ===== design/nfcs_queue.sv =====
module nfcs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nfcs_pkg::op_t push_op,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output nfcs_pkg::op_t head
);

  nfcs_pkg::op_t                 mem_r [nfcs_pkg::QDEPTH];
  logic [nfcs_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [nfcs_pkg::QCNT_W-1:0]   count_r, count_nxt;

  assign full  = (count_r == nfcs_pkg::QCNT_W'(nfcs_pkg::QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== design/nfcs_back.sv =====
module nfcs_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           op_valid,
  input  nfcs_pkg::op_t  op,
  output logic           pop,
  output logic           res_valid,
  input  logic           res_ready,
  output nfcs_pkg::res_t res
);

  logic [nfcs_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        valid_r, valid_nxt;
  nfcs_pkg::res_t              res_r;
  nfcs_pkg::res_t              cur;
  logic                        load;

  assign cur  = nfcs_pkg::seq_result(op, step_r);
  assign load = op_valid && (!valid_r || res_ready);
  assign pop  = load && cur.last;

  always_comb begin
    step_nxt  = step_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      step_nxt  = cur.last ? '0 : step_r + 1'b1;
    end else if (res_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign res_valid = valid_r;
  assign res       = res_r;

endmodule

// ===== design/nor_flash_command_sequencer.sv =====
// An accepted transaction is written into the operation queue, and the back end then registers
// its first result. One result per cycle from the back end's sequence step counter while the
//   output is not stalled; an item gives one result (read, seek, error), four (program) or six (erase).
// The input stays ready while the two-entry operation queue has room.
// Reset (rst_n low at a clock edge): position 0, flash size 8 MiB, queue and output empty.
module nor_flash_command_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: flash_size in bytes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,
  // Operations
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // opcode[2:0], target_addr[25:3], write_data[41:26], zero
  // Bus sequence results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // bus_valid[0], bus_write[1], bus_word_addr[23:2],
                                  // bus_data[39:24], status[40], position[63:41],
                                  // wait_us[78:64], zero[79]
  output logic        out_tlast
);

  nfcs_pkg::op_t  push_op, head_op;
  nfcs_pkg::res_t res;
  logic           push, pop, q_full, q_empty;

  // Configuration writes are always taken; the user only writes while idle.
  assign cfg_ready = 1'b1;

  // Accept a transaction whenever the queue has room.
  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  // Front: classify the operation, check range and alignment, advance the position.
  nfcs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .push        (push),
    .opcode      (in_tdata[2:0]),
    .target_addr (in_tdata[25:3]),
    .write_data  (in_tdata[41:26]),
    .op          (push_op)
  );

  // Hold classified operations until the back end is free.
  nfcs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .full    (q_full),
    .empty   (q_empty),
    .head    (head_op)
  );

  // Back: step through the unlock and command cycles, one result per cycle unless stalled.
  nfcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (!q_empty),
    .op        (head_op),
    .pop       (pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {1'b0, res.wait_us, res.position, res.status, res.bus_data,
                      res.bus_word_addr, res.bus_write, res.bus_valid};
  assign out_tlast = res.last;

  // An error result never carries a bus cycle and always ends its operation.
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[40] |-> out_tlast && !out_tdata[0])
    else $error("error result with bus cycle or not last");

  // Wait time appears on the final result only.
  a_wait_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[78:64] == '0)
    else $error("wait time on a non-final result");

  // The back end only pops an operation that is present in the queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("queue pop while empty");

  // A stalled output holds while the queue drains no entry.
  a_stall_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !pop)
    else $error("operation popped while output stalled");

endmodule
